[hdl/lbs_pkg.sv]
// Shared types and constants for the leftmost binary search core.
// No dependencies.
`timescale 1ns / 1ps

package lbs_pkg;

	localparam int CFG_W = 11;
	localparam int IDX_W = 10;
	localparam int VAL_W = 32;
	localparam int POS_W = 10;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int WORD_WIDTH_DEF  = 32;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CHECK,
		ST_PRED,
		ST_FINISH
	} lbs_state_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} lbs_result_t;

endpackage

[hdl/lbs_ifs.sv]
// Valid/ready channel interfaces: request items, result items, count register writes.
// Depends on lbs_pkg.
`timescale 1ns / 1ps

interface lbs_req_if;
	import lbs_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic [IDX_W-1:0]        entry_index;
	logic signed [VAL_W-1:0] value;
	modport source (output valid, kind, entry_index, value, input ready);
	modport sink (input valid, kind, entry_index, value, output ready);
endinterface

interface lbs_rsp_if;
	import lbs_pkg::*;
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;
	modport source (output valid, found, position, input ready);
	modport sink (input valid, found, position, output ready);
endinterface

interface lbs_cfg_if;
	import lbs_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] entry_count;
	modport source (output valid, entry_count, input ready);
	modport sink (input valid, entry_count, output ready);
endinterface

[hdl/leftmost_binary_search_core.sv]
// Leftmost binary search core: entry count register, search sequencer, result register.
// Depends on lbs_pkg, lbs_ifs and lbs_ctrl.
// A write is taken only while idle. A search is accepted; each probe then reads the RAM and
// checks the word (a match also reads its predecessor) until a leftmost hit or empty range, and
// its result item is handed off. At most 11 probes for 1024 entries via the single RAM read port.
// Reset clears the entry count and all control state; table contents stay undefined.
`timescale 1ns / 1ps

module leftmost_binary_search_core #(
	parameter int  TABLE_DEPTH = lbs_pkg::TABLE_DEPTH_DEF,
	parameter int  WORD_WIDTH  = lbs_pkg::WORD_WIDTH_DEF,
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1),
	localparam int SAT_W       = (CNT_W > lbs_pkg::CFG_W) ? CNT_W : lbs_pkg::CFG_W,
	localparam int PX_W        = (CNT_W > lbs_pkg::POS_W) ? CNT_W : lbs_pkg::POS_W
) (
	input  logic       clk,
	input  logic       arst_n,
	lbs_req_if.sink    req,
	lbs_rsp_if.source  rsp,
	lbs_cfg_if.sink    cfg
);

	import lbs_pkg::*;

	logic [CFG_W-1:0] count_q;
	logic [SAT_W-1:0] count_wide;
	logic [CNT_W-1:0] count_sat;
	logic             res_valid;
	logic             res_take;
	lbs_result_t      res;
	logic             rsp_valid_q;
	lbs_result_t      rsp_data_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg.valid) begin
			count_q <= cfg.entry_count;
		end
	end

	assign count_wide = (SAT_W'(count_q) > SAT_W'(TABLE_DEPTH)) ? SAT_W'(TABLE_DEPTH)
	                                                            : SAT_W'(count_q);
	assign count_sat  = count_wide[CNT_W-1:0];

	lbs_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.count    (count_sat),
		.res_valid(res_valid),
		.res      (res),
		.res_take (res_take)
	);

	assign res_take = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			rsp_data_q <= res;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.found    = rsp_data_q.found;
	assign rsp.position = rsp_data_q.position;

	a_res_loads: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_take |=> rsp.valid)
		else $error("result item not loaded into output register");

	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.position == '0)
		else $error("not-found item carries nonzero position");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> PX_W'(rsp.position) < PX_W'(count_sat))
		else $error("found position outside the searched range");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req.ready)
		else $error("request accepted while a search result is pending");

endmodule

[hdl/lbs_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lbs_ram #(
	parameter int  WIDTH = 32,
	parameter int  DEPTH = 1024,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/lbs_ctrl.sv]
// Search sequencer: table writes and the probe loop over the table RAM.
// Depends on lbs_pkg, lbs_ifs and lbs_ram.
`timescale 1ns / 1ps

module lbs_ctrl #(
	parameter int  TABLE_DEPTH = lbs_pkg::TABLE_DEPTH_DEF,
	parameter int  WORD_WIDTH  = lbs_pkg::WORD_WIDTH_DEF,
	localparam int AW          = $clog2(TABLE_DEPTH),
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1),
	localparam int IX_W        = (CNT_W > lbs_pkg::IDX_W) ? CNT_W : lbs_pkg::IDX_W,
	localparam int VX_W        = (WORD_WIDTH > lbs_pkg::VAL_W) ? WORD_WIDTH : lbs_pkg::VAL_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lbs_req_if.sink              req,
	input  logic [CNT_W-1:0]     count,
	output logic                 res_valid,
	output lbs_pkg::lbs_result_t res,
	input  logic                 res_take
);

	import lbs_pkg::*;

	localparam logic [WORD_WIDTH-1:0] SIGN_BIT = {1'b1, {(WORD_WIDTH-1){1'b0}}};

	lbs_state_t            state_q, state_d;
	logic [CNT_W-1:0]      lo_q, lo_d, hi_q, hi_d;
	logic [AW-1:0]         mid_q, mid_d;
	logic [CNT_W-1:0]      mid_c;
	logic [IX_W-1:0]       mid_wide;
	logic [WORD_WIDTH-1:0] key_q;
	lbs_result_t           res_q, res_d;

	logic [IX_W-1:0]       wr_idx_wide;
	logic [VX_W-1:0]       wr_val_wide;
	logic [WORD_WIDTH-1:0] in_word;
	logic                  idx_ok;
	logic                  we;
	logic [AW-1:0]         raddr;
	logic [WORD_WIDTH-1:0] rdata;
	logic                  here_eq, here_lt;

	assign wr_idx_wide = IX_W'(req.entry_index);
	assign wr_val_wide = VX_W'($unsigned(req.value));
	assign in_word     = wr_val_wide[WORD_WIDTH-1:0];
	assign idx_ok      = wr_idx_wide < IX_W'(TABLE_DEPTH);
	assign we          = req.valid && req.ready && (req.kind == KIND_WRITE) && idx_ok;

	assign mid_c    = lo_q + ((hi_q - lo_q) >> 1);
	assign mid_wide = IX_W'(mid_q);
	assign here_eq  = rdata == key_q;
	assign here_lt  = (rdata ^ SIGN_BIT) < (key_q ^ SIGN_BIT);
	assign res      = res_q;

	lbs_ram #(
		.WIDTH(WORD_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(wr_idx_wide[AW-1:0]),
		.wdata(in_word),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
			res_q   <= '0;
		end else begin
			state_q <= state_d;
			lo_q    <= lo_d;
			hi_q    <= hi_d;
			mid_q   <= mid_d;
			res_q   <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready && (req.kind == KIND_SEARCH)) begin
			key_q <= in_word;
		end
	end

	always_comb begin
		state_d   = state_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		mid_d     = mid_q;
		res_d     = res_q;
		raddr     = mid_c[AW-1:0];
		res_valid = 1'b0;
		req.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && (req.kind == KIND_SEARCH)) begin
					lo_d    = '0;
					hi_d    = count;
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (lo_q < hi_q) begin
					mid_d   = mid_c[AW-1:0];
					state_d = ST_CHECK;
				end else begin
					res_d   = '0;
					state_d = ST_FINISH;
				end
			end
			ST_CHECK: begin
				if (here_eq) begin
					if (mid_q == '0) begin
						res_d.found    = 1'b1;
						res_d.position = mid_wide[POS_W-1:0];
						state_d        = ST_FINISH;
					end else begin
						raddr   = mid_q - AW'(1);
						state_d = ST_PRED;
					end
				end else if (here_lt) begin
					lo_d    = CNT_W'(mid_q) + CNT_W'(1);
					state_d = ST_PROBE;
				end else begin
					hi_d    = CNT_W'(mid_q);
					state_d = ST_PROBE;
				end
			end
			ST_PRED: begin
				if (!here_eq) begin
					res_d.found    = 1'b1;
					res_d.position = mid_wide[POS_W-1:0];
					state_d        = ST_FINISH;
				end else begin
					hi_d    = CNT_W'(mid_q);
					state_d = ST_PROBE;
				end
			end
			ST_FINISH: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[tb/sv/lbs_checker.sv]
// Checker for the leftmost binary search core: mirrors the table and the entry count,
// predicts each search result and compares it with the result channel.
// Depends on lbs_pkg and lbs_ifs.
`timescale 1ns / 1ps

module lbs_checker
	import lbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	lbs_req_if          req,
	lbs_rsp_if          rsp,
	lbs_cfg_if          cfg,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	logic signed [VAL_W-1:0] words_mirror [TABLE_DEPTH_DEF];
	logic [CFG_W-1:0]        active_count;
	lbs_result_t             expected_q [$];
	lbs_result_t             got;
	lbs_result_t             want;
	int unsigned             err_cnt = 0;

	function automatic lbs_result_t lower_bound_search(input logic signed [VAL_W-1:0] key);
		lbs_result_t r;
		int lo;
		int hi;
		int mid;
		r = '0;
		lo = 0;
		hi = (active_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(active_count);
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (words_mirror[mid] == key && (mid == 0 || words_mirror[mid - 1] != key)) begin
				r.found = 1'b1;
				r.position = POS_W'(mid);
				return r;
			end else if (words_mirror[mid] < key) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count = '0;
			expected_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.found = rsp.found;
				got.position = rsp.position;
				if (expected_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result: expected none, actual found=%0b position=%0d",
						$time, got.found, got.position);
				end else begin
					want = expected_q.pop_front();
					if (got.found !== want.found) begin
						err_cnt++;
						$display("%0t: found mismatch: expected %0b, actual %0b",
							$time, want.found, got.found);
					end
					if (got.position !== want.position) begin
						err_cnt++;
						$display("%0t: position mismatch: expected %0d, actual %0d",
							$time, want.position, got.position);
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.kind == KIND_WRITE) begin
					words_mirror[req.entry_index] = req.value;
				end else begin
					expected_q.push_back(lower_bound_search(req.value));
				end
			end
			if (cfg.valid && cfg.ready) begin
				active_count = cfg.entry_count;
			end
		end
		mismatches <= err_cnt;
		outstanding <= expected_q.size();
	end

endmodule

[tb/sv/testbench.sv]
// Top of the leftmost binary search testbench: clock, reset, stimulus, watchdog, verdict.
// Depends on lbs_pkg, lbs_ifs, lbs_checker and the leftmost_binary_search_core RTL.
`timescale 1ns / 1ps

module testbench;
	import lbs_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int QUIET_LIMIT   = 2000;
	localparam int ROUNDS        = 14;
	localparam int ROUND_ITEMS   = 42;
	localparam logic signed [VAL_W-1:0] WORD_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] WORD_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lbs_req_if req ();
	lbs_rsp_if rsp ();
	lbs_cfg_if cfg ();

	int unsigned mismatches;
	int unsigned outstanding;
	int snd_idle_pct = 13;
	int rcv_idle_pct = 45;
	int quiet_cycles = 0;
	int n_writes = 0;
	int n_searches = 0;
	int n_counts = 0;
	logic signed [VAL_W-1:0] shadow [TABLE_DEPTH_DEF];

	leftmost_binary_search_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	lbs_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg         (cfg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: watchdog expired, no handshake for %0d cycles", $time, quiet_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic push_item(input logic k, input logic [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] v);
		if ($urandom_range(0, 99) < snd_idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= k;
		req.entry_index <= idx;
		req.value <= v;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic send_write(input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] v);
		push_item(KIND_WRITE, idx, v);
		shadow[idx] = v;
		n_writes++;
	endtask

	task automatic send_search(input logic signed [VAL_W-1:0] key);
		push_item(KIND_SEARCH, IDX_W'($urandom_range(0, TABLE_DEPTH_DEF - 1)), key);
		n_searches++;
	endtask

	// drop valid, drain all results, then let trailing writes settle
	task automatic wait_idle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_count(input int n);
		wait_idle();
		cfg.valid <= 1'b1;
		cfg.entry_count <= CFG_W'(n);
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		n_counts++;
	endtask

	task automatic write_sorted_run(input int len, input longint lo_v, input longint hi_v);
		longint cur;
		longint stride;
		int i;
		cur = lo_v;
		stride = ((hi_v - lo_v) / ((len > 0) ? len : 1)) * 2;
		if (stride < 1) stride = 1;
		for (i = 0; i < len; i++) begin
			send_write(IDX_W'(i), cur[VAL_W-1:0]);
			if ($urandom_range(0, 2) != 0) begin
				cur += 1 + longint'({$urandom(), $urandom()} >> 1) % stride;
			end
			if (cur > hi_v) cur = hi_v;
		end
	endtask

	task automatic run_round(input int cnt);
		int eff;
		int sel;
		int k;
		int j;
		longint lo_v;
		logic signed [VAL_W-1:0] key;
		set_count(cnt);
		eff = (cnt > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : cnt;
		if (eff > 0 && eff <= 64) begin
			case ($urandom_range(0, 3))
				0: lo_v = longint'(WORD_MIN);
				1: lo_v = longint'(WORD_MAX) - 200;
				2: lo_v = -100;
				default: lo_v = longint'($signed($urandom()));
			endcase
			write_sorted_run(eff, lo_v,
				(lo_v + 200 > longint'(WORD_MAX)) ? longint'(WORD_MAX) : lo_v + 200);
		end
		for (k = 0; k < ROUND_ITEMS; k++) begin
			sel = $urandom_range(0, 99);
			if (eff > 0 && sel < 60) begin
				send_search(shadow[$urandom_range(0, eff - 1)]);
			end else if (eff > 0 && sel < 72) begin
				key = shadow[$urandom_range(0, eff - 1)];
				send_search($urandom_range(0, 1) ? key + 1 : key - 1);
			end else if (sel < 85) begin
				send_search($urandom());
			end else if (sel < 93 || eff < 2) begin
				send_write(IDX_W'($urandom_range(0, TABLE_DEPTH_DEF - 1)), $urandom());
			end else begin
				j = $urandom_range(1, eff - 1);
				send_write(IDX_W'(j), shadow[j - 1]);
			end
		end
	endtask

	initial begin : stimulus
		int r;
		int cnt;
		req.valid = 1'b0;
		req.kind = KIND_WRITE;
		req.entry_index = '0;
		req.value = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.entry_count = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty range straight after reset
		send_search(VAL_W'(0));
		send_write(IDX_W'(0), WORD_MIN);
		send_write(IDX_W'(1), WORD_MIN);
		send_write(IDX_W'(2), VAL_W'(-5));
		send_write(IDX_W'(3), VAL_W'(0));
		send_write(IDX_W'(4), VAL_W'(0));
		send_write(IDX_W'(5), VAL_W'(0));
		send_write(IDX_W'(6), VAL_W'(7));
		send_write(IDX_W'(7), WORD_MAX);
		set_count(8);
		send_search(WORD_MIN);
		send_search(VAL_W'(0));
		send_search(WORD_MAX);
		send_search(VAL_W'(-5));
		send_search(VAL_W'(3));
		send_search(VAL_W'(-1));
		send_search(VAL_W'(8));
		set_count(1);
		send_search(WORD_MIN);
		send_search(WORD_MAX);

		// fill the whole table with sorted content
		write_sorted_run(TABLE_DEPTH_DEF, longint'(WORD_MIN), longint'(WORD_MAX));

		for (r = 0; r < ROUNDS; r++) begin
			if (r == 5) begin
				snd_idle_pct = 45;
				rcv_idle_pct = 13;
			end else if (r == 10) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			case (r % 7)
				0: cnt = TABLE_DEPTH_DEF;
				1: cnt = (r < 7) ? 0 : 1;
				3: cnt = (r < 7) ? 2047 : $urandom_range(TABLE_DEPTH_DEF + 1, 2047);
				5: cnt = (r < 7) ? 1 : 2;
				default: cnt = $urandom_range(2, 48);
			endcase
			run_round(cnt);
		end

		wait_idle();
		$display("Covered %0d table writes and %0d searches over %0d entry count settings,",
			n_writes, n_searches, n_counts);
		$display("from an empty range through a full table to a saturated count.");
		if (mismatches == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[files.f]
hdl/lbs_pkg.sv
hdl/lbs_ifs.sv
hdl/lbs_ram.sv
hdl/lbs_ctrl.sv
hdl/leftmost_binary_search_core.sv
tb/sv/lbs_checker.sv
tb/sv/testbench.sv
